// ===== rtl/fea_pkg.sv =====
// Package for the frame to Euler angles block.
// Holds widths, CORDIC constants and the pipeline payload type. No dependencies.
package fea_pkg;
   localparam int IN_W = 31;
   localparam int OUT_W = 19;
   localparam int THR_W = 16;
   localparam int DW = 36;
   localparam int ZW = 24;
   localparam int STAGES_DEF = 16;
   localparam int FRAC_DEF = 16;
   localparam logic [31:0] GAIN_Q30 = 32'd652032874;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [15:0] THR_RESET = 16'd1;

   function automatic logic [31:0] atan_q30(input int i);
      case (i)
         0: atan_q30 = 32'd843314857;
         1: atan_q30 = 32'd497837829;
         2: atan_q30 = 32'd263043837;
         3: atan_q30 = 32'd133525159;
         4: atan_q30 = 32'd67021687;
         5: atan_q30 = 32'd33543516;
         6: atan_q30 = 32'd16775851;
         7: atan_q30 = 32'd8388437;
         8: atan_q30 = 32'd4194283;
         9: atan_q30 = 32'd2097149;
         default: atan_q30 = (i < 31) ? (32'd1 << (30 - i)) : 32'd0;
      endcase
   endfunction

   function automatic logic signed [ZW-1:0] to_frac(input logic [31:0] q, input int fb);
      logic [32:0] s;
      s = {1'b0, q};
      if (fb < 30) s = s + (33'd1 << (29 - fb));
      to_frac = ZW'(s >> (30 - fb));
   endfunction

   typedef struct packed {
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      logic signed [DW-1:0] c;
      logic signed [DW-1:0] d;
      logic signed [ZW-1:0] z;
      logic                 act;
      logic                 follow;
   } cell_type;
endpackage

// ===== rtl/fea_if.sv =====
// Valid/ready channel interfaces for the frame to Euler angles block.
// Depends on nothing.
interface fea_req_if;
   logic valid;
   logic ready;
   logic signed [30:0] xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z;
   modport source(output valid, xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
                  input ready);
   modport sink(input valid, xaxis_x, xaxis_y, xaxis_z, yaxis_x, yaxis_y, yaxis_z,
                output ready);
endinterface

interface fea_rsp_if;
   logic valid;
   logic ready;
   logic signed [18:0] angle_about_x, angle_about_y, angle_about_z;
   modport source(output valid, angle_about_x, angle_about_y, angle_about_z, input ready);
   modport sink(input valid, angle_about_x, angle_about_y, angle_about_z, output ready);
endinterface

interface fea_csr_if;
   logic valid;
   logic ready;
   logic [15:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

// ===== rtl/fea_cell.sv =====
// One CORDIC micro-rotation cell with its output register.
// Depends on fea_pkg.
module fea_cell #(
   parameter int SHIFT = 0,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  fea_pkg::cell_type  d_in,
   output fea_pkg::cell_type  q_out
);
   import fea_pkg::*;
   cell_type r_in, r_ff;
   logic signed [ZW-1:0] ang;
   assign ang = to_frac(atan_q30(SHIFT), FRAC_BITS);
   always_comb begin
      r_in = d_in;
      if (d_in.act) begin
         if (!d_in.b[DW-1]) begin
            r_in.a = d_in.a + (d_in.b >>> SHIFT);
            r_in.b = d_in.b - (d_in.a >>> SHIFT);
            if (d_in.follow) begin
               r_in.c = d_in.c + (d_in.d >>> SHIFT);
               r_in.d = d_in.d - (d_in.c >>> SHIFT);
            end
            r_in.z = d_in.z + ang;
         end else begin
            r_in.a = d_in.a - (d_in.b >>> SHIFT);
            r_in.b = d_in.b + (d_in.a >>> SHIFT);
            if (d_in.follow) begin
               r_in.c = d_in.c - (d_in.d >>> SHIFT);
               r_in.d = d_in.d + (d_in.c >>> SHIFT);
            end
            r_in.z = d_in.z - ang;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) r_ff <= r_in;
   end
   assign q_out = r_ff;
endmodule

// ===== rtl/fea_run.sv =====
// One vectoring run: zero test and quarter turn, a chain of cells, gain correction.
// Depends on fea_pkg and fea_cell.
module fea_run #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [fea_pkg::THR_W-1:0]   thr,
   input  logic signed [fea_pkg::DW-1:0] x_i, y_i, u_i, v_i,
   output logic signed [fea_pkg::DW-1:0] x_o, y_o, u_o, v_o,
   output logic signed [fea_pkg::ZW-1:0] z_o
);
   import fea_pkg::*;
   localparam int NS = (CORDIC_STAGES < 31) ? CORDIC_STAGES : 31;
   cell_type head;
   cell_type chain [NS+1];
   logic signed [DW-1:0] px_ff, py_ff, pu_ff, pv_ff;
   logic signed [DW+31:0] m0, m1, m2, m3;
   logic act_ff;
   logic signed [ZW-1:0] z_ff;

   function automatic logic below_thr(input logic signed [DW-1:0] a,
                                      input logic [THR_W-1:0] t);
      logic signed [DW-1:0] m;
      m = a[DW-1] ? -a : a;
      below_thr = m <= $signed({{(DW-THR_W){1'b0}}, t});
   endfunction

   function automatic logic signed [DW-1:0] gfix(input logic signed [DW+31:0] p);
      logic signed [DW+31:0] s;
      s = p + (DW+32)'(64'sd1 <<< 29);
      gfix = DW'(s >>> 30);
   endfunction

   always_comb begin
      head.a = x_i; head.b = y_i; head.c = u_i; head.d = v_i;
      head.z = '0;
      head.act = !(below_thr(x_i, thr) && below_thr(y_i, thr));
      head.follow = !(below_thr(u_i, thr) && below_thr(v_i, thr));
      if (head.act && x_i[DW-1]) begin
         if (!y_i[DW-1]) begin
            head.a = y_i; head.b = -x_i;
            if (head.follow) begin
               head.c = v_i; head.d = -u_i;
            end
            head.z = to_frac(HALF_PI_Q30, FRAC_BITS);
         end else begin
            head.a = -y_i; head.b = x_i;
            if (head.follow) begin
               head.c = -v_i; head.d = u_i;
            end
            head.z = -to_frac(HALF_PI_Q30, FRAC_BITS);
         end
      end
   end
   assign chain[0] = head;

   for (genvar i = 0; i < NS; i++) begin : g_cell
      fea_cell #(.SHIFT(i), .FRAC_BITS(FRAC_BITS)) u_cell (
         .clock(clock), .en(en), .d_in(chain[i]), .q_out(chain[i+1]));
   end

   assign m0 = (DW+32)'(chain[NS].a) * $signed({1'b0, GAIN_Q30});
   assign m1 = (DW+32)'(chain[NS].b) * $signed({1'b0, GAIN_Q30});
   assign m2 = (DW+32)'(chain[NS].c) * $signed({1'b0, GAIN_Q30});
   assign m3 = (DW+32)'(chain[NS].d) * $signed({1'b0, GAIN_Q30});

   always_ff @(posedge clock) begin
      if (en) begin
         act_ff <= chain[NS].act;
         z_ff <= chain[NS].act ? chain[NS].z : '0;
         px_ff <= chain[NS].act ? gfix(m0) : chain[NS].a;
         py_ff <= chain[NS].act ? gfix(m1) : chain[NS].b;
         pu_ff <= (chain[NS].act && chain[NS].follow) ? gfix(m2) : chain[NS].c;
         pv_ff <= (chain[NS].act && chain[NS].follow) ? gfix(m3) : chain[NS].d;
      end
   end
   assign x_o = px_ff; assign y_o = py_ff; assign u_o = pu_ff; assign v_o = pv_ff;
   assign z_o = act_ff ? z_ff : '0;
endmodule

// ===== rtl/frame_to_euler_angles.sv =====
// Top level of the frame to Euler angles block: three CORDIC runs in a row.
// Depends on fea_pkg, fea_if and fea_run.
//
// Usage: a frame's x and y axis vectors (signed Q14.16) arrive as one
// transaction on req; three Q2.16 angles leave on rsp. csr writes the
// near-zero threshold and is always ready; write it only while idle.
// The pipeline advances whenever the output register is empty or taken,
// so one transaction is accepted every cycle unless the receiver stalls.
// Each run is a chain of registered cells and a gain-correction register,
// and delay stages carry the angles and untouched components along. When
// the receiver stalls, the whole chain freezes and req.ready falls. Reset
// empties the pipeline and sets the threshold to 1.
module frame_to_euler_angles #(
   parameter int CORDIC_STAGES = fea_pkg::STAGES_DEF,
   parameter int FRAC_BITS = fea_pkg::FRAC_DEF
) (
   input logic clock,
   input logic reset,
   fea_req_if.sink req,
   fea_rsp_if.source rsp,
   fea_csr_if.sink csr
);
   import fea_pkg::*;
   localparam int NS = (CORDIC_STAGES < 31) ? CORDIC_STAGES : 31;
   localparam int RL = NS + 1;
   localparam int TOT = 3 * RL + 1;
   logic [THR_W-1:0] thr_ff;
   logic [TOT-1:0] vld_ff;
   logic en;
   logic signed [DW-1:0] px0, py0, pz0, qx0, qy0, qz0;
   logic signed [DW-1:0] ax, ay, au, av, bx, bz, bu, bw, cy, cz, cu, cv;
   logic signed [ZW-1:0] zz, zy, zx;
   logic signed [DW-1:0] pz_d [RL], qz_d [RL], pz_in1, qz_in1;
   logic signed [DW-1:0] qy_d [RL], qy_in2;
   logic signed [ZW-1:0] zz_d [RL], zz_d2 [RL], zy_d [RL];
   logic signed [OUT_W-1:0] ox_ff, oy_ff, oz_ff;

   assign en = !vld_ff[TOT-1] || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;
   assign px0 = DW'(req.xaxis_x); assign py0 = DW'(req.xaxis_y);
   assign pz0 = DW'(req.xaxis_z); assign qx0 = DW'(req.yaxis_x);
   assign qy0 = DW'(req.yaxis_y); assign qz0 = DW'(req.yaxis_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         vld_ff <= '0;
      end else begin
         if (csr.valid) thr_ff <= csr.data;
         if (en) vld_ff <= {vld_ff[TOT-2:0], req.valid};
      end
   end

   fea_run #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_run_z (
      .clock(clock), .en(en), .thr(thr_ff), .x_i(px0), .y_i(py0), .u_i(qx0),
      .v_i(qy0), .x_o(ax), .y_o(ay), .u_o(au), .v_o(av), .z_o(zz));

   always_ff @(posedge clock) begin
      if (en) begin
         pz_d[0] <= pz0; qz_d[0] <= qz0; qy_d[0] <= av;
         for (int i = 1; i < RL; i++) begin
            pz_d[i] <= pz_d[i-1]; qz_d[i] <= qz_d[i-1]; qy_d[i] <= qy_d[i-1];
         end
         zz_d[0] <= zz; zz_d2[0] <= zz_d[RL-1]; zy_d[0] <= zy;
         for (int i = 1; i < RL; i++) begin
            zz_d[i] <= zz_d[i-1]; zz_d2[i] <= zz_d2[i-1]; zy_d[i] <= zy_d[i-1];
         end
      end
   end
   assign pz_in1 = pz_d[RL-1];
   assign qz_in1 = qz_d[RL-1];
   assign qy_in2 = qy_d[RL-1];

   fea_run #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_run_y (
      .clock(clock), .en(en), .thr(thr_ff), .x_i(ax), .y_i(pz_in1), .u_i(au),
      .v_i(qz_in1), .x_o(bx), .y_o(bz), .u_o(bu), .v_o(bw), .z_o(zy));

   fea_run #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_run_x (
      .clock(clock), .en(en), .thr(thr_ff), .x_i(qy_in2), .y_i(bw), .u_i('0),
      .v_i('0), .x_o(cy), .y_o(cz), .u_o(cu), .v_o(cv), .z_o(zx));

   always_ff @(posedge clock) begin
      if (en) begin
         ox_ff <= OUT_W'(zx);
         oy_ff <= OUT_W'(-zy_d[RL-1]);
         oz_ff <= OUT_W'(zz_d2[RL-1]);
      end
   end

   assign rsp.valid = vld_ff[TOT-1];
   assign rsp.angle_about_x = ox_ff;
   assign rsp.angle_about_y = oy_ff;
   assign rsp.angle_about_z = oz_ff;

   logic unused;
   assign unused = ^{ay, bx, bz, bu, cy, cz, cu, cv};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(ox_ff))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready) else $error("ready low with empty output");
   a_thr: assert property (@(posedge clock) disable iff (reset)
      csr.valid |=> thr_ff == $past(csr.data)) else $error("threshold not written");
endmodule

// ===== verif/frame_to_euler_angles_test.sv =====
// Self-checking testbench for frame_to_euler_angles: frames are sent on req and
// the angles on rsp are compared against a built-in CORDIC angle predictor.
// Depends on fea_pkg, the fea_if channel interfaces and the RTL top level.
`timescale 1ns / 1ps

module frame_to_euler_angles_test;
   import fea_pkg::*;

   typedef struct {
      logic signed [30:0] px, py, pz, qx, qy, qz;
   } frame_type;

   typedef struct {
      logic signed [18:0] ax, ay, az;
   } angles_type;

   typedef struct {
      frame_type  f;
      logic       pinned;
      angles_type want;
   } stim_row_type;

   localparam int STAGE_COUNT = 16;
   localparam int DRAIN_CYCLES = 3 * (STAGE_COUNT + 1) + 12;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 3000;
   localparam longint GAIN = 64'd652032874;
   localparam longint HALF_PI = 64'd1686629713;
   localparam longint ATAN_TABLE [0:15] = '{843314857, 497837829, 263043837, 133525159,
      67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768};
   localparam logic signed [30:0] MAXV = 31'sh3FFFFFFF;
   localparam logic signed [30:0] MINV = -31'sh40000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fea_req_if req_ch();
   fea_rsp_if rsp_ch();
   fea_csr_if csr_ch();

   frame_to_euler_angles DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   always #1 clock = ~clock;

   angles_type angle_queue [$];
   longint     threshold = 1;
   int         errors = 0;
   logic       moved = 1'b0;
   logic       calm = 1'b0;
   logic       long_hold = 1'b0;
   logic       pin_valid = 1'b0;
   angles_type pin_value;

   function automatic longint frac_of(longint q);
      return (q + 64'sd8192) >>> 14;
   endfunction

   function automatic longint gain_fix(longint v);
      return (v * GAIN + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic near_zero(longint a, longint b, longint thr);
      return (a < 0 ? -a : a) <= thr && (b < 0 ? -b : b) <= thr;
   endfunction

   function automatic longint vector_to_axis(inout longint x, inout longint y,
                                             inout longint u, inout longint v,
                                             input longint thr);
      longint a, b, c, d, t, z, na, nb, nc, nd;
      logic follow;
      a = x; b = y; c = u; d = v; z = 0;
      follow = !near_zero(c, d, thr);
      if (a < 0) begin
         if (b >= 0) begin
            t = a; a = b; b = -t;
            t = c; c = d; d = -t;
            z = frac_of(HALF_PI);
         end else begin
            t = a; a = -b; b = t;
            t = c; c = -d; d = t;
            z = -frac_of(HALF_PI);
         end
      end
      for (int i = 0; i < STAGE_COUNT; i++) begin
         if (b >= 0) begin
            na = a + (b >>> i); nb = b - (a >>> i);
            nc = c + (d >>> i); nd = d - (c >>> i);
            z += frac_of(ATAN_TABLE[i]);
         end else begin
            na = a - (b >>> i); nb = b + (a >>> i);
            nc = c - (d >>> i); nd = d + (c >>> i);
            z -= frac_of(ATAN_TABLE[i]);
         end
         a = na; b = nb; c = nc; d = nd;
      end
      x = gain_fix(a);
      y = gain_fix(b);
      if (follow) begin
         u = gain_fix(c);
         v = gain_fix(d);
      end
      return z;
   endfunction

   function automatic angles_type euler_angles(frame_type f, longint thr);
      longint px, py, pz, qx, qy, qz, rx, ry, rz, t0, t1;
      angles_type r;
      px = f.px; py = f.py; pz = f.pz; qx = f.qx; qy = f.qy; qz = f.qz;
      rx = 0; ry = 0; rz = 0;
      if (!near_zero(px, py, thr)) rz = vector_to_axis(px, py, qx, qy, thr);
      if (!near_zero(px, pz, thr)) ry = -vector_to_axis(px, pz, qx, qz, thr);
      if (!near_zero(qy, qz, thr)) begin
         t0 = 0; t1 = 0;
         rx = vector_to_axis(qy, qz, t0, t1, thr);
      end
      r.ax = rx[18:0];
      r.ay = ry[18:0];
      r.az = rz[18:0];
      return r;
   endfunction

   function automatic logic signed [30:0] random_component();
      case ($urandom_range(0, 5))
         0: return 31'($urandom());
         1: return 31'($signed($urandom_range(0, 8)) - 4);
         2: return 31'($signed($urandom_range(0, 262143)) - 131072);
         3: return $urandom_range(0, 1) ? MAXV : MINV;
         4: return 31'($signed($urandom_range(0, 131070)) - 65535);
         default: return 31'($signed($urandom_range(0, 4194303)) - 2097152);
      endcase
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      f.px = random_component(); f.py = random_component(); f.pz = random_component();
      f.qx = random_component(); f.qy = random_component(); f.qz = random_component();
      if ($urandom_range(0, 7) == 0) begin
         f.qx = 0; f.qy = 0; f.qz = 0;
      end
      return f;
   endfunction

   // Acceptance is sampled on the falling edge, where all inputs and outputs are stable.
   always @(negedge clock) begin
      angles_type e;
      frame_type f;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            f.px = req_ch.xaxis_x; f.py = req_ch.xaxis_y; f.pz = req_ch.xaxis_z;
            f.qx = req_ch.yaxis_x; f.qy = req_ch.yaxis_y; f.qz = req_ch.yaxis_z;
            angle_queue.push_back(pin_valid ? pin_value : euler_angles(f, threshold));
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (angle_queue.size() == 0) begin
               $display("%0t: unexpected transaction x=%0d y=%0d z=%0d", $time,
                        rsp_ch.angle_about_x, rsp_ch.angle_about_y, rsp_ch.angle_about_z);
               errors++;
            end else begin
               e = angle_queue.pop_front();
               if (rsp_ch.angle_about_x !== e.ax) begin
                  $display("%0t: angle_about_x expected %0d actual %0d", $time, e.ax,
                           rsp_ch.angle_about_x);
                  errors++;
               end
               if (rsp_ch.angle_about_y !== e.ay) begin
                  $display("%0t: angle_about_y expected %0d actual %0d", $time, e.ay,
                           rsp_ch.angle_about_y);
                  errors++;
               end
               if (rsp_ch.angle_about_z !== e.az) begin
                  $display("%0t: angle_about_z expected %0d actual %0d", $time, e.az,
                           rsp_ch.angle_about_z);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      int stalled;
      if (reset) begin
         stalled = 0;
      end else begin
         stalled = moved ? 0 : stalled + 1;
         moved = 1'b0;
         if (stalled >= STALL_LIMIT) begin
            $display("frame_to_euler_angles_test: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         n = calm ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (!rsp_ch.valid);
         @(posedge clock);
      end
   end

   task automatic send_frame(frame_type f, logic pinned, angles_type want);
      int n;
      n = calm ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.xaxis_x <= f.px; req_ch.xaxis_y <= f.py; req_ch.xaxis_z <= f.pz;
      req_ch.yaxis_x <= f.qx; req_ch.yaxis_y <= f.qy; req_ch.yaxis_z <= f.qz;
      pin_valid = pinned;
      pin_value = want;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      do @(negedge clock); while (!csr_ch.ready);
      threshold = value;
      moved = 1'b1;
      @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   stim_row_type directed [] = '{
      '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0}},
      '{'{1, -1, 0, 0, 1, -1}, 1'b1, '{0, 0, 0}},
      '{'{-1, 1, 1, 1, -1, 0}, 1'b1, '{0, 0, 0}},
      '{'{65536, 0, 0, 0, 65536, 0}, 1'b0, '{0, 0, 0}},
      '{'{0, 65536, 0, -65536, 0, 0}, 1'b0, '{0, 0, 0}},
      '{'{-65536, 0, 0, 0, -65536, 0}, 1'b0, '{0, 0, 0}},
      '{'{-65536, 1000, 0, 0, 0, 65536}, 1'b0, '{0, 0, 0}},
      '{'{-65536, -1000, 0, 0, 0, -65536}, 1'b0, '{0, 0, 0}},
      '{'{0, 0, 65536, 0, 65536, 0}, 1'b0, '{0, 0, 0}},
      '{'{0, 0, -65536, 65536, 0, 0}, 1'b0, '{0, 0, 0}},
      '{'{65536, 0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0}},
      '{'{65536, 65536, 0, 1, 0, 1}, 1'b0, '{0, 0, 0}},
      '{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1'b0, '{0, 0, 0}},
      '{'{MINV, MINV, MINV, MINV, MINV, MINV}, 1'b0, '{0, 0, 0}},
      '{'{MAXV, MINV, MAXV, MINV, MAXV, MINV}, 1'b0, '{0, 0, 0}},
      '{'{MINV, MAXV, MINV, MAXV, MINV, MAXV}, 1'b0, '{0, 0, 0}},
      '{'{MINV, 0, 0, 0, MAXV, MINV}, 1'b0, '{0, 0, 0}},
      '{'{2, 0, 0, 0, 2, 0}, 1'b0, '{0, 0, 0}},
      '{'{0, 0, 2, 0, 0, -2}, 1'b0, '{0, 0, 0}},
      '{'{45000, 45000, 32768, -30000, 40000, 22000}, 1'b0, '{0, 0, 0}}
   };

   initial begin
      logic [15:0] settings [5];
      angles_type none;
      none = '{0, 0, 0};
      req_ch.valid = 1'b0;
      req_ch.xaxis_x = 0; req_ch.xaxis_y = 0; req_ch.xaxis_z = 0;
      req_ch.yaxis_x = 0; req_ch.yaxis_y = 0; req_ch.yaxis_z = 0;
      csr_ch.valid = 1'b0;
      csr_ch.data = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_frame(directed[i].f, directed[i].pinned, directed[i].want);
      drain_results();

      settings = '{16'd0, 16'd65535, 16'($urandom()), 16'd1, 16'($urandom_range(0, 300))};
      for (int p = 0; p < 5; p++) begin
         write_threshold(settings[p]);
         for (int k = 0; k < 380; k++) begin
            if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            if (p == 1 && k == 100) long_hold = 1'b1;
            if (p == 2 && k == 150) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (angle_queue.size() != 0) @(posedge clock);
            end
            send_frame(random_frame(), 1'b0, none);
         end
         drain_results();
      end

      if (errors == 0) begin
         $display("frame_to_euler_angles_test: done, clean");
      end else begin
         $display("frame_to_euler_angles_test: done, errors");
      end
      $finish;
   end
endmodule
